FILE: design/rkg_pkg.sv
// Shared types, constants and the arctangent table of the radial k-space gridder.
`default_nettype none
package rkg_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic signed [28:0] PI_Q24 = 29'sd52707179;
	localparam logic signed [28:0] HALF_PI_Q24 = 29'sd26353589;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] MARK_BITS = 32'h42C8_0000;
	localparam logic signed [43:0] COORD_BIAS = 44'sd8192;

	typedef enum logic [1:0] {
		CFG_GRID_WIDTH = 2'd0,
		CFG_CENTER_COLUMN = 2'd1,
		CFG_DELTA_K = 2'd2,
		CFG_MARK_ONLY = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [27:0] radius;
		logic signed [28:0] angle;
		logic fold_neg;
		logic [31:0] re;
		logic [31:0] im;
	} rkg_entry_t;

	function automatic logic signed [28:0] atan_q24(input int step);
		logic signed [28:0] a;
		case (step)
			0: a = 29'sd13176795;
			1: a = 29'sd7778716;
			2: a = 29'sd4110060;
			3: a = 29'sd2086331;
			4: a = 29'sd1047214;
			5: a = 29'sd524117;
			6: a = 29'sd262123;
			7: a = 29'sd131069;
			8: a = 29'sd65536;
			9: a = 29'sd32768;
			10: a = 29'sd16384;
			11: a = 29'sd8192;
			12: a = 29'sd4096;
			13: a = 29'sd2048;
			14: a = 29'sd1024;
			default: a = 29'sd512;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: design/rkg_front.sv
// Front end: classifies an item, computes its radius and folds its angle.
`default_nettype none
module rkg_front
	import rkg_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024
) (
	input wire logic [9:0] sample_index,
	input wire logic signed [15:0] ray_angle,
	input wire logic [31:0] sample_re,
	input wire logic [31:0] sample_im,
	input wire logic line_acquired,
	input wire logic [9:0] center_column,
	input wire logic [15:0] delta_k_q8,
	input wire logic mark_only,
	output rkg_entry_t entry,
	output logic keep
);
	logic signed [10:0] diff;
	logic signed [28:0] z;

	always_comb begin
		keep = line_acquired && (13'(sample_index) < 13'(MAX_COLUMNS));
		diff = $signed({1'b0, sample_index}) - $signed({1'b0, center_column});
		entry.radius = 28'(diff) * $signed({12'b0, delta_k_q8});
		z = {{2{ray_angle[15]}}, ray_angle, 11'b0};
		entry.fold_neg = 1'b0;
		entry.angle = z;
		if (z > HALF_PI_Q24) begin
			entry.angle = z - PI_Q24;
			entry.fold_neg = 1'b1;
		end else if (z < -HALF_PI_Q24) begin
			entry.angle = z + PI_Q24;
			entry.fold_neg = 1'b1;
		end
		entry.re = mark_only ? MARK_BITS : sample_re;
		entry.im = mark_only ? MARK_BITS : sample_im;
	end
endmodule
`default_nettype wire

FILE: design/rkg_queue.sv
// Short queue that decouples the front end from the geometry pipeline.
`default_nettype none
module rkg_queue
	import rkg_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rkg_entry_t wr_data,
	input wire logic pop,
	output rkg_entry_t rd_data,
	output logic not_empty,
	output logic not_full
);
	rkg_entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0] count_q;

	assign not_empty = count_q != '0;
	assign not_full = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("push lost");
	a_pop_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("pop lost");
`endif
endmodule
`default_nettype wire

FILE: design/rkg_back.sv
// Back end: pipelined CORDIC, scaling, clamping and address generation.
`default_nettype none
module rkg_back
	import rkg_pkg::*;
#(
	parameter int MAX_GRID_WIDTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire rkg_entry_t entry,
	output logic in_ready,
	input wire logic [10:0] grid_width,
	output logic out_valid,
	input wire logic out_ready,
	output logic [9:0] x_index,
	output logic [9:0] y_index,
	output logic [19:0] grid_address,
	output logic [31:0] value_re,
	output logic [31:0] value_im
);
	localparam int WW = $clog2(MAX_GRID_WIDTH + 1);
	localparam int NS = CORDIC_STEPS + 1;

	logic adv;
	logic [13:0] w14;
	logic [WW-1:0] w, half_w;

	logic v_s [NS];
	logic signed [33:0] cx_s [NS];
	logic signed [33:0] cy_s [NS];
	logic signed [28:0] cz_s [CORDIC_STEPS];
	logic signed [27:0] rad_s [NS];
	logic neg_s [NS];
	logic [31:0] re_s [NS];
	logic [31:0] im_s [NS];

	logic v_trig_s, v_mul_s, v_crd_s, out_valid_q;
	logic signed [15:0] cos_s, sin_s;
	logic signed [27:0] rad_trig_s;
	logic signed [43:0] px_s, py_s;
	logic [WW-1:0] xi_s, yi_s;
	logic [31:0] re_trig_s, im_trig_s, re_mul_s, im_mul_s, re_crd_s, im_crd_s;
	logic [9:0] x_index_q, y_index_q;
	logic [19:0] grid_address_q;
	logic [31:0] value_re_q, value_im_q;

	function automatic logic signed [15:0] to_q15(input logic signed [33:0] v, input logic n);
		logic signed [33:0] t;
		logic signed [19:0] c;
		t = (v + 34'sd16384) >>> 15;
		c = 20'(t);
		if (n) c = -c;
		if (c > 20'sd32767) c = 20'sd32767;
		if (c < -20'sd32768) c = -20'sd32768;
		return 16'(c);
	endfunction

	function automatic logic [WW-1:0] coord(input logic signed [43:0] p,
			input logic [WW-1:0] hw, input logic [WW-1:0] wd);
		logic signed [43:0] t;
		logic signed [WW+21:0] q;
		logic [WW-1:0] r;
		t = (p + COORD_BIAS) >>> 23;
		q = (WW+22)'(t) + $signed({22'b0, hw});
		if (q < 0) r = '0;
		else if (q > $signed({22'b0, wd - 1'b1})) r = wd - 1'b1;
		else r = WW'(q);
		return r;
	endfunction

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		w14 = 14'(grid_width);
		if (w14 < 14'd2) w14 = 14'd2;
		else if (w14 > 14'(MAX_GRID_WIDTH)) w14 = 14'(MAX_GRID_WIDTH);
		w = WW'(w14);
		half_w = w >> 1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0] <= CORDIC_GAIN_Q30;
			cy_s[0] <= '0;
			cz_s[0] <= entry.angle;
			rad_s[0] <= entry.radius;
			neg_s[0] <= entry.fold_neg;
			re_s[0] <= entry.re;
			im_s[0] <= entry.im;
		end
	end

	// Each generated stage performs one CORDIC micro-rotation.
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				if (cz_s[k] >= 0) begin
					cx_s[k+1] <= cx_s[k] - (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] + (cx_s[k] >>> k);
				end else begin
					cx_s[k+1] <= cx_s[k] + (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] - (cx_s[k] >>> k);
				end
				rad_s[k+1] <= rad_s[k];
				neg_s[k+1] <= neg_s[k];
				re_s[k+1] <= re_s[k];
				im_s[k+1] <= im_s[k];
			end
		end
		// The residual angle is not needed after the last rotation.
		if (k < CORDIC_STEPS - 1) begin : g_angle
			always_ff @(posedge clk) begin
				if (adv) begin
					if (cz_s[k] >= 0) cz_s[k+1] <= cz_s[k] - atan_q24(k);
					else cz_s[k+1] <= cz_s[k] + atan_q24(k);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (adv) v_s[k+1] <= v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s <= to_q15(cx_s[NS-1], neg_s[NS-1]);
			sin_s <= to_q15(cy_s[NS-1], neg_s[NS-1]);
			rad_trig_s <= rad_s[NS-1];
			re_trig_s <= re_s[NS-1];
			im_trig_s <= im_s[NS-1];
			px_s <= 44'(rad_trig_s) * 44'(cos_s);
			py_s <= 44'(rad_trig_s) * 44'(sin_s);
			re_mul_s <= re_trig_s;
			im_mul_s <= im_trig_s;
			xi_s <= coord(px_s, half_w, w);
			yi_s <= coord(py_s, half_w, w);
			re_crd_s <= re_mul_s;
			im_crd_s <= im_mul_s;
			x_index_q <= 10'(xi_s);
			y_index_q <= 10'(yi_s);
			grid_address_q <= 20'((2*WW)'(yi_s) * (2*WW)'(w) + (2*WW)'(xi_s));
			value_re_q <= re_crd_s;
			value_im_q <= im_crd_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
			v_trig_s <= 1'b0;
			v_mul_s <= 1'b0;
			v_crd_s <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			v_trig_s <= v_s[NS-1];
			v_mul_s <= v_trig_s;
			v_crd_s <= v_mul_s;
			out_valid_q <= v_crd_s;
		end
	end

	assign out_valid = out_valid_q;
	assign x_index = x_index_q;
	assign y_index = y_index_q;
	assign grid_address = grid_address_q;
	assign value_re = value_re_q;
	assign value_im = value_im_q;
endmodule
`default_nettype wire

FILE: design/radial_kspace_nearest_gridder.sv
// An accepted item passes through the queue, the CORDIC stages and the trig, multiply, coordinate and output registers.
// Throughput: one item per cycle while the output is not stalled, set by the fully pipelined 16-stage CORDIC.
// Items on unacquired lines or beyond the line length are dropped at the front end.
// A stalled output freezes the back pipeline; a four-item queue absorbs the front.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults.
`default_nettype none
module radial_kspace_nearest_gridder
	import rkg_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_GRID_WIDTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [9:0] sample_index,
	input wire logic signed [15:0] ray_angle,
	input wire logic [31:0] sample_re,
	input wire logic [31:0] sample_im,
	input wire logic line_acquired,
	output logic out_valid,
	input wire logic out_ready,
	output logic [9:0] x_index,
	output logic [9:0] y_index,
	output logic [19:0] grid_address,
	output logic [31:0] value_re,
	output logic [31:0] value_im,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	logic [10:0] grid_width_q;
	logic [9:0] center_column_q;
	logic [15:0] delta_k_q8_q;
	logic mark_only_q;

	rkg_entry_t front_entry, queue_entry;
	logic keep, q_not_empty, q_not_full, back_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 11'd256;
			center_column_q <= 10'd128;
			delta_k_q8_q <= 16'd256;
			mark_only_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_GRID_WIDTH: grid_width_q <= cfg_data[10:0];
				CFG_CENTER_COLUMN: center_column_q <= cfg_data[9:0];
				CFG_DELTA_K: delta_k_q8_q <= cfg_data;
				CFG_MARK_ONLY: mark_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rkg_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.sample_index(sample_index),
		.ray_angle(ray_angle),
		.sample_re(sample_re),
		.sample_im(sample_im),
		.line_acquired(line_acquired),
		.center_column(center_column_q),
		.delta_k_q8(delta_k_q8_q),
		.mark_only(mark_only_q),
		.entry(front_entry),
		.keep(keep)
	);

	assign in_ready = q_not_full;

	rkg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid && q_not_full && keep),
		.wr_data(front_entry),
		.pop(back_ready && q_not_empty),
		.rd_data(queue_entry),
		.not_empty(q_not_empty),
		.not_full(q_not_full)
	);

	rkg_back #(.MAX_GRID_WIDTH(MAX_GRID_WIDTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_not_empty),
		.entry(queue_entry),
		.in_ready(back_ready),
		.grid_width(grid_width_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_index(x_index),
		.y_index(y_index),
		.grid_address(grid_address),
		.value_re(value_re),
		.value_im(value_im)
	);
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the radial k-space nearest-cell gridder.
`timescale 1ns / 1ps
module tb;
	import rkg_pkg::*;

	localparam int MAX_COLS = 1024;
	localparam int MAX_WIDTH = 1024;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [9:0] x;
		logic [9:0] y;
		logic [19:0] addr;
		logic [31:0] re;
		logic [31:0] im;
	} cell_write_t;

	class cell_write_board;
		cell_write_t pending[$];
		int errors = 0;
		longint width = 256;
		longint center = 128;
		longint delta_k = 256;
		bit marker = 0;

		function void set_reg(cfg_index_t idx, logic [15:0] data);
			case (idx)
				CFG_GRID_WIDTH: width = data[10:0];
				CFG_CENTER_COLUMN: center = data[9:0];
				CFG_DELTA_K: delta_k = data;
				CFG_MARK_ONLY: marker = data[0];
				default: ;
			endcase
		endfunction

		// Rounds a Q2.30 CORDIC output to Q1.15, undoing the fold and saturating.
		function longint round_q15(longint v, bit neg);
			longint c;
			c = (v + 16384) >>> 15;
			if (neg)
				c = -c;
			if (c > 32767)
				c = 32767;
			if (c < -32768)
				c = -32768;
			return c;
		endfunction

		function void rotate(logic signed [15:0] angle, output longint c, output longint s);
			longint z, x, y, dx, dy;
			bit neg;
			z = longint'(angle) * 2048;
			x = CORDIC_GAIN_Q30;
			y = 0;
			neg = 0;
			if (z > HALF_PI_Q24) begin
				z -= PI_Q24;
				neg = 1;
			end else if (z < -HALF_PI_Q24) begin
				z += PI_Q24;
				neg = 1;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_q24(i);
				end else begin
					x += dx;
					y -= dy;
					z += atan_q24(i);
				end
			end
			c = round_q15(x, neg);
			s = round_q15(y, neg);
		endfunction

		function longint cell_coord(longint r, longint t, longint w);
			longint p;
			p = ((r * t + 8192) >>> 23) + w / 2;
			if (p < 0)
				p = 0;
			if (p > w - 1)
				p = w - 1;
			return p;
		endfunction

		function void note_sample(logic [9:0] idx, logic signed [15:0] angle,
				logic [31:0] re, logic [31:0] im, logic acquired);
			cell_write_t e;
			longint w, r, c, s, xi, yi;
			if (!acquired || idx >= MAX_COLS)
				return;
			w = width;
			if (w < 2)
				w = 2;
			if (w > MAX_WIDTH)
				w = MAX_WIDTH;
			r = (longint'(idx) - center) * delta_k;
			rotate(angle, c, s);
			xi = cell_coord(r, c, w);
			yi = cell_coord(r, s, w);
			e.x = xi[9:0];
			e.y = yi[9:0];
			e.addr = 20'(yi * w + xi);
			e.re = marker ? MARK_BITS : re;
			e.im = marker ? MARK_BITS : im;
			pending.push_back(e);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_write(logic [9:0] x, logic [9:0] y, logic [19:0] addr,
				logic [31:0] re, logic [31:0] im);
			cell_write_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected cell write x=%0d y=%0d", x, y));
				return;
			end
			e = pending.pop_front();
			if (x !== e.x)
				report($sformatf("x_index %0d, expected %0d", x, e.x));
			if (y !== e.y)
				report($sformatf("y_index %0d, expected %0d", y, e.y));
			if (addr !== e.addr)
				report($sformatf("grid_address %0d, expected %0d", addr, e.addr));
			if (re !== e.re)
				report($sformatf("value_re %h, expected %h", re, e.re));
			if (im !== e.im)
				report($sformatf("value_im %h, expected %h", im, e.im));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [9:0] sample_index;
	logic signed [15:0] ray_angle;
	logic [31:0] sample_re;
	logic [31:0] sample_im;
	logic line_acquired;
	logic out_valid;
	logic out_ready;
	logic [9:0] x_index;
	logic [9:0] y_index;
	logic [19:0] grid_address;
	logic [31:0] value_re;
	logic [31:0] value_im;
	logic cfg_valid;
	logic cfg_ready;
	cfg_index_t cfg_index;
	logic [15:0] cfg_data;

	cell_write_board board = new();
	bit quiet = 0;
	int stall_cycles = 0;

	radial_kspace_nearest_gridder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_index(sample_index), .ray_angle(ray_angle),
		.sample_re(sample_re), .sample_im(sample_im), .line_acquired(line_acquired),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_index(x_index), .y_index(y_index), .grid_address(grid_address),
		.value_re(value_re), .value_im(value_im),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
	end

	// Result checking and the no-progress watchdog share one sampling point.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_write(x_index, y_index, grid_address, value_re, value_im);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired at %0t", $time);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task send_sample(logic [9:0] idx, logic signed [15:0] angle,
			logic [31:0] re, logic [31:0] im, logic acquired);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_index <= idx;
		ray_angle <= angle;
		sample_re <= re;
		sample_im <= im;
		line_acquired <= acquired;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_sample(idx, angle, re, im, acquired);
	endtask

	task send_random_sample();
		logic [9:0] idx;
		logic signed [15:0] angle;
		if ($urandom_range(3) == 0)
			idx = 10'($urandom_range(1023));
		else
			idx = 10'(board.center) + 10'($urandom_range(40)) - 10'd20;
		if ($urandom_range(9) == 0)
			angle = 16'($urandom);
		else
			angle = 16'($signed($urandom_range(51472)) - 25736);
		send_sample(idx, angle, $urandom, $urandom, $urandom_range(9) != 0);
	endtask

	// Lets the block empty out, including items that give no result.
	task drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(cfg_index_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_reg(idx, data);
	endtask

	task set_geometry(logic [15:0] w, logic [15:0] c, logic [15:0] dk, logic m);
		drain();
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_CENTER_COLUMN, c);
		write_reg(CFG_DELTA_K, dk);
		write_reg(CFG_MARK_ONLY, {15'd0, m});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		sample_index = 0;
		ray_angle = 0;
		sample_re = 0;
		sample_im = 0;
		line_acquired = 0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_data = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed items on the reset geometry: index and angle extremes,
		// angles past plus or minus pi, and an unacquired line.
		send_sample(10'd0, 16'sd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		send_sample(10'd1023, 16'sd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		send_sample(10'd128, 16'sd0, 32'h3F80_0000, 32'hBF80_0000, 1'b1);
		send_sample(10'd255, 16'sd25736, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
		send_sample(10'd0, -16'sd25736, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
		send_sample(10'd200, 16'sd12868, 32'h1, 32'h2, 1'b1);
		send_sample(10'd200, -16'sd12868, 32'h3, 32'h4, 1'b1);
		send_sample(10'd200, 16'sd12869, 32'h5, 32'h6, 1'b1);
		send_sample(10'd60, 16'sd32767, 32'h7, 32'h8, 1'b1);
		send_sample(10'd60, 16'sh8000, 32'h9, 32'hA, 1'b1);
		send_sample(10'd300, 16'sd6434, 32'hB, 32'hC, 1'b0);
		send_sample(10'd1023, 16'sd19302, 32'hD, 32'hE, 1'b1);
		send_sample(10'd0, -16'sd6434, 32'hF, 32'h10, 1'b1);

		// Each phase drains the block, loads a geometry, then streams samples.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_geometry(16'd2, 16'd0, 16'd65535, 1'b1);
				1: set_geometry(16'd1024, 16'd1023, 16'd1, 1'b0);
				2: set_geometry(16'd0, 16'd512, 16'd0, 1'b0);
				3: set_geometry(16'd2047, 16'd512, 16'd300, 1'b1);
				4: set_geometry(16'd1, 16'd300, 16'd4000, 1'b0);
				5: set_geometry(16'($urandom_range(2, 1024)), 16'($urandom_range(1023)),
					16'($urandom_range(1, 65535)), 1'($urandom_range(1)));
				default: set_geometry(16'd256, 16'd128, 16'd256, 1'b0);
			endcase
			quiet = (phase == 6);
			for (int n = 0; n < 78; n++) begin
				if (phase == 1 && n == 40)
					drain();
				send_random_sample();
			end
			quiet = 0;
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
